FILE: sv/itpsm_pkg.sv
// Shared types and constants for the IPv4 text parser and subnet matcher.
// No dependencies.
package itpsm_pkg;

  // string selector carried on the input tuser
  typedef enum logic [1:0] {
    KIND_NETWORK = 2'd0,
    KIND_MASK    = 2'd1,
    KIND_TESTED  = 2'd2,
    KIND_FLUSH   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    VERDICT_OUTSIDE = 2'd0,
    VERDICT_INSIDE  = 2'd1,
    VERDICT_ERROR   = 2'd2,
    VERDICT_UNUSED  = 2'd3
  } verdict_e;

  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharNine = 8'h39;
  localparam logic [7:0] CharDot  = 8'h2E;

  localparam logic [2:0] DotsNeeded = 3'd3;
  localparam logic [5:0] PrefixMax  = 6'd32;

  localparam int unsigned OutTdataW = 40;

endpackage

FILE: sv/ipv4_text_parse_subnet_match_core.sv
// Top level of the IPv4 dotted-decimal parser and subnet matcher.
// Depends on itpsm_pkg.
//
// Usage:
//   Slave stream carries one character per item: tdata = character, tuser =
//   string kind (0 network, 1 mask, 2 tested, 3 flush), tlast = terminator.
//   Characters only update the parser. A terminator of kind 0, 1 or 2 yields
//   one result on the master stream; kind 3 only clears the parser.
//   Master tdata holds parsed_value in [31:0] and verdict in [33:32]; tuser
//   is verdict_valid, set for the terminator of the tested address.
//   Throughput: one item per cycle while no terminator waits for the
//   result slot. An accepted item is parsed out of the input register, and
//   a terminator's result is written into the result register and offered.
//   When the receiver stalls, the result register holds its item and the
//   input register still takes one more item; characters keep draining
//   while a result waits, and a further terminator waits in the input
//   register until the result slot frees.
//   Reset clears the parser, the saved network and mask and both valid
//   flags; a verdict before a network and mask are given is error.
module ipv4_text_parse_subnet_match_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // character
  input  logic [1:0]  s_axis_tuser_i,   // string_kind
  input  logic        s_axis_tlast_i,   // is_end
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // parsed_value[31:0], verdict[33:32], zero fill
  output logic [itpsm_pkg::OutTdataW-1:0] m_axis_tdata_o,
  output logic        m_axis_tuser_o    // verdict_valid
);

  // input register
  logic       in_vld_q;
  logic [7:0] in_char_q;
  logic [1:0] in_kind_q;
  logic       in_end_q;

  // parser state
  logic [7:0]  octet_q, octet_d;
  logic [23:0] shift_q, shift_d;
  logic        digit_seen_q, digit_seen_d;
  logic [2:0]  dots_q, dots_d;
  logic        dotted_bad_q, dotted_bad_d;
  logic [5:0]  prefix_q, prefix_d;
  logic        prefix_bad_q, prefix_bad_d;
  logic [31:0] net_q, net_d;
  logic [31:0] mask_q, mask_d;

  // result register
  logic        out_vld_q;
  logic [31:0] out_value_q, out_value_d;
  logic        out_vv_q, out_vv_d;
  logic [1:0]  out_verdict_q, out_verdict_d;

  logic        in_fire;
  logic        produces;
  logic        out_free;
  logic        advance;
  logic        is_digit;
  logic        is_dot;
  logic [3:0]  digit;
  logic [8:0]  prefix_sum;
  logic        dotted_ok;
  logic [31:0] dotted_val;
  logic [31:0] mask_val;
  logic [4:0]  mask_shift;
  logic [31:0] result_val;

  assign produces = in_end_q && (in_kind_q != itpsm_pkg::KIND_FLUSH);
  assign out_free = !out_vld_q || m_axis_tready_i;
  assign advance  = in_vld_q && (!produces || out_free);
  assign s_axis_tready_o = !in_vld_q || advance;
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;

  assign is_digit = (in_char_q >= itpsm_pkg::CharZero) && (in_char_q <= itpsm_pkg::CharNine);
  assign is_dot   = (in_char_q == itpsm_pkg::CharDot);
  assign digit    = in_char_q[3:0];
  // prefix*10 + digit; prefix never exceeds 32 so nine bits suffice
  assign prefix_sum = {prefix_q, 3'b000} + {2'b00, prefix_q, 1'b0} + {5'b00000, digit};

  assign dotted_ok  = !dotted_bad_q && digit_seen_q && (dots_q == itpsm_pkg::DotsNeeded);
  assign dotted_val = dotted_ok ? {shift_q, octet_q} : 32'd0;
  assign mask_shift = 5'(itpsm_pkg::PrefixMax - prefix_q);

  always_comb begin
    if (dotted_ok) begin
      mask_val = dotted_val;
    end else if (prefix_bad_q || (prefix_q == 6'd0)) begin
      mask_val = 32'd0;
    end else if (prefix_q >= itpsm_pkg::PrefixMax) begin
      mask_val = 32'hFFFF_FFFF;
    end else begin
      mask_val = 32'hFFFF_FFFF << mask_shift;
    end
  end

  assign result_val = (in_kind_q == itpsm_pkg::KIND_MASK) ? mask_val : dotted_val;

  always_comb begin
    octet_d      = octet_q;
    shift_d      = shift_q;
    digit_seen_d = digit_seen_q;
    dots_d       = dots_q;
    dotted_bad_d = dotted_bad_q;
    prefix_d     = prefix_q;
    prefix_bad_d = prefix_bad_q;
    net_d        = net_q;
    mask_d       = mask_q;
    out_value_d   = result_val;
    out_vv_d      = 1'b0;
    out_verdict_d = itpsm_pkg::VERDICT_OUTSIDE;
    if (in_end_q) begin
      // every terminator clears the parser
      octet_d      = '0;
      shift_d      = '0;
      digit_seen_d = 1'b0;
      dots_d       = '0;
      dotted_bad_d = 1'b0;
      prefix_d     = '0;
      prefix_bad_d = 1'b0;
      unique case (in_kind_q)
        itpsm_pkg::KIND_NETWORK: net_d = dotted_val;
        itpsm_pkg::KIND_MASK:    mask_d = mask_val;
        itpsm_pkg::KIND_TESTED: begin
          out_vv_d = 1'b1;
          if ((net_q == 32'd0) || (mask_q == 32'd0) || (dotted_val == 32'd0)) begin
            out_verdict_d = itpsm_pkg::VERDICT_ERROR;
          end else if ((net_q & mask_q) == (dotted_val & mask_q)) begin
            out_verdict_d = itpsm_pkg::VERDICT_INSIDE;
          end else begin
            out_verdict_d = itpsm_pkg::VERDICT_OUTSIDE;
          end
        end
        default: ;
      endcase
    end else if (is_digit) begin
      octet_d      = 8'({octet_q, 3'b000} + {octet_q, 1'b0} + {7'd0, digit});
      digit_seen_d = 1'b1;
      prefix_d     = (prefix_sum > 9'(itpsm_pkg::PrefixMax)) ? itpsm_pkg::PrefixMax
                                                             : prefix_sum[5:0];
    end else if (is_dot) begin
      prefix_bad_d = 1'b1;
      if (!digit_seen_q || (dots_q >= itpsm_pkg::DotsNeeded)) begin
        dotted_bad_d = 1'b1;
      end else begin
        shift_d      = {shift_q[15:0], octet_q};
        octet_d      = '0;
        digit_seen_d = 1'b0;
        dots_d       = dots_q + 3'd1;
      end
    end else begin
      prefix_bad_d = 1'b1;
      dotted_bad_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_char_q <= s_axis_tdata_i;
      in_kind_q <= s_axis_tuser_i;
      in_end_q  <= s_axis_tlast_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      octet_q      <= '0;
      shift_q      <= '0;
      digit_seen_q <= 1'b0;
      dots_q       <= '0;
      dotted_bad_q <= 1'b0;
      prefix_q     <= '0;
      prefix_bad_q <= 1'b0;
      net_q        <= '0;
      mask_q       <= '0;
    end else if (advance) begin
      octet_q      <= octet_d;
      shift_q      <= shift_d;
      digit_seen_q <= digit_seen_d;
      dots_q       <= dots_d;
      dotted_bad_q <= dotted_bad_d;
      prefix_q     <= prefix_d;
      prefix_bad_q <= prefix_bad_d;
      net_q        <= net_d;
      mask_q       <= mask_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= advance && produces;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && produces) begin
      out_value_q   <= out_value_d;
      out_vv_q      <= out_vv_d;
      out_verdict_q <= out_verdict_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {6'd0, out_verdict_q, out_value_q};
  assign m_axis_tuser_o  = out_vv_q;

`ifndef NO_ASSERTIONS
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |-> s_axis_tready_o)
    else $error("input register empty but not ready");

  a_verdict_zero_without_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_vv_q) |-> (out_verdict_q == itpsm_pkg::VERDICT_OUTSIDE))
    else $error("verdict set on a non-tested result");

  a_inside_needs_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_vv_q && (out_verdict_q == itpsm_pkg::VERDICT_INSIDE))
      |-> (out_value_q != 32'd0))
    else $error("inside verdict with zero tested address");

  a_dot_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dots_q <= itpsm_pkg::DotsNeeded)
    else $error("dot count beyond three");

  a_prefix_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prefix_q <= itpsm_pkg::PrefixMax)
    else $error("prefix accumulator not saturated");
`endif

endmodule
